FILE: sv/hac_pkg.sv
// Shared types, constants and codes of the double-ended hunk allocator.
package hac_pkg;

    // Hunk geometry and slot table depth
    localparam int unsigned HUNK_BYTES = 4194304;
    localparam int TEMP_SLOTS = 16;
    localparam int ADDR_W = 23;
    localparam int SUM_W = ADDR_W + 2;
    localparam int CNT_W = 5;
    localparam int IDX_W = (TEMP_SLOTS > 1) ? $clog2(TEMP_SLOTS) : 1;
    localparam int OP_W = 3;
    localparam int ERR_W = 3;
    localparam int ALIGN_MASK = 7;

    // Stream payload widths, padded to whole bytes
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_BUMP   = 3'd0,
        OP_MARK   = 3'd1,
        OP_RESET  = 3'd2,
        OP_TALLOC = 3'd3,
        OP_TFREE  = 3'd4,
        OP_CHECK  = 3'd5
    } t_op;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK       = 3'd0,
        ERR_FRONT    = 3'd1,
        ERR_BACK     = 3'd2,
        ERR_SLOTS    = 3'd3,
        ERR_BADRST   = 3'd4,
        ERR_NOTFOUND = 3'd5,
        ERR_HELD     = 3'd6
    } t_err;

    // Control broadcast from the sequencer to every slot cell
    typedef struct packed {
        logic              push;   // write wdata into the cell at index cnt
        logic              step;   // advance the chain one place toward cell 0
        logic              keep;   // recycle the head value to the tail
        logic [CNT_W-1:0]  cnt;    // current number of occupied cells
        logic [ADDR_W-1:0] head;   // value leaving cell 0
        logic [ADDR_W-1:0] wdata;  // value to append on push
    } t_cell_ctl;

endpackage

FILE: sv/hac_cell.sv
// One slot cell of the temporary allocation chain.
module hac_cell (
    input  logic                      i_clk,
    input  logic [hac_pkg::IDX_W-1:0] i_index,
    input  hac_pkg::t_cell_ctl        i_ctl,
    input  logic [hac_pkg::ADDR_W-1:0] i_next,
    output logic [hac_pkg::ADDR_W-1:0] o_val
);

    logic [hac_pkg::ADDR_W-1:0] r_val;
    logic [hac_pkg::CNT_W-1:0]  w_pos;
    logic [hac_pkg::CNT_W-1:0]  w_pos1;

    assign w_pos  = hac_pkg::CNT_W'(i_index);
    assign w_pos1 = w_pos + hac_pkg::CNT_W'(1);

    // Append at the fill point, or shift in from the right neighbor, or take the head at the tail
    always_ff @(posedge i_clk) begin
        if (i_ctl.push && (w_pos == i_ctl.cnt)) begin
            r_val <= i_ctl.wdata;
        end else if (i_ctl.step && (w_pos1 < i_ctl.cnt)) begin
            r_val <= i_next;
        end else if (i_ctl.step && i_ctl.keep && (w_pos1 == i_ctl.cnt)) begin
            r_val <= i_ctl.head;
        end
    end

    assign o_val = r_val;

endmodule

FILE: sv/double_ended_hunk_allocator_core.sv
// Top level of the double-ended hunk allocator: sequencer, levels and slot chain.
//
// Usage: one command transaction on the slave stream (op, req_size, req_addr in
// s_tdata) yields exactly one result transaction on the master stream
// (result_addr, error_code, temp_count in m_tdata). Bump alloc, mark, reset
// front, temp alloc and check finish in the accept cycle; the result appears
// on the master stream in the cycle after the command transaction.
// Temp free rotates the slot chain once per occupied slot, cell 0 presented
// to the compare and max logic each cycle, and then publishes its result from
// the S_FIN state; a free that fails the address range check, or finds the
// table empty, answers from the accept cycle like the other commands.
// One command is worked on at a time: s_tready is high only while the
// sequencer is idle and the result register is empty or being drained.
// A stalled receiver holds the result register, and s_tready stays low until
// the result transaction completes.
// Reset (i_rst_n low at a clock edge) clears both levels and the slot count;
// slot contents are undefined until written and are only read below the count.
module double_ended_hunk_allocator_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // [2:0] op, [25:3] req_size, [48:26] req_addr, [55:49] zero
    input  logic [hac_pkg::S_DATA_W-1:0]  i_s_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [22:0] result_addr, [25:23] error_code, [30:26] temp_count, [31] zero
    output logic [hac_pkg::M_DATA_W-1:0]  o_m_tdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

    localparam logic [hac_pkg::SUM_W-1:0] HUNK_S = hac_pkg::SUM_W'(hac_pkg::HUNK_BYTES);
    localparam logic [hac_pkg::CNT_W-1:0] SLOTS_C = hac_pkg::CNT_W'(hac_pkg::TEMP_SLOTS);

    t_state                     r_state, n_state;
    logic [hac_pkg::ADDR_W-1:0] r_front, n_front;
    logic [hac_pkg::ADDR_W-1:0] r_back, n_back;
    logic [hac_pkg::CNT_W-1:0]  r_count, n_count;
    logic [hac_pkg::CNT_W-1:0]  r_left, n_left;
    logic [hac_pkg::ADDR_W-1:0] r_key, n_key;
    logic [hac_pkg::ADDR_W-1:0] r_best, n_best;
    logic                       r_found, n_found;
    logic                       r_out_valid, n_out_valid;
    logic [hac_pkg::ADDR_W-1:0] r_res_addr, n_res_addr;
    hac_pkg::t_err              r_res_err, n_res_err;
    logic [hac_pkg::CNT_W-1:0]  r_res_cnt, n_res_cnt;

    hac_pkg::t_cell_ctl         w_ctl;
    logic [hac_pkg::ADDR_W-1:0] w_val [hac_pkg::TEMP_SLOTS];

    logic                       w_accept;
    hac_pkg::t_op               w_op;
    logic [hac_pkg::ADDR_W-1:0] w_size;
    logic [hac_pkg::ADDR_W-1:0] w_addr;
    logic [hac_pkg::SUM_W-1:0]  w_used;
    logic [hac_pkg::SUM_W-1:0]  w_bump_sum;
    logic [hac_pkg::SUM_W-1:0]  w_front_sum;
    logic [hac_pkg::SUM_W-1:0]  w_rsize;
    logic [hac_pkg::SUM_W-1:0]  w_temp_sum;
    logic [hac_pkg::SUM_W-1:0]  w_back_sum;
    logic [hac_pkg::ADDR_W-1:0] w_new_back;
    logic [hac_pkg::SUM_W-1:0]  w_talloc_addr;
    logic [hac_pkg::SUM_W-1:0]  w_key_diff;
    logic                       w_match;

    // Unpack the command and form the level arithmetic
    assign w_op   = hac_pkg::t_op'(i_s_tdata[2:0]);
    assign w_size = i_s_tdata[25:3];
    assign w_addr = i_s_tdata[48:26];

    assign w_used        = hac_pkg::SUM_W'(r_front) + hac_pkg::SUM_W'(r_back);
    assign w_bump_sum    = w_used + hac_pkg::SUM_W'(w_size);
    assign w_front_sum   = hac_pkg::SUM_W'(r_front) + hac_pkg::SUM_W'(w_size);
    assign w_rsize       = (hac_pkg::SUM_W'(w_size) + hac_pkg::SUM_W'(hac_pkg::ALIGN_MASK))
                         & ~hac_pkg::SUM_W'(hac_pkg::ALIGN_MASK);
    assign w_temp_sum    = w_used + w_rsize;
    assign w_back_sum    = hac_pkg::SUM_W'(r_back) + w_rsize;
    assign w_new_back    = w_back_sum[hac_pkg::ADDR_W-1:0];
    assign w_talloc_addr = HUNK_S - w_back_sum;
    assign w_key_diff    = HUNK_S - hac_pkg::SUM_W'(w_addr);
    assign w_match       = (w_val[0] == r_key);

    assign o_s_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_tready);
    assign w_accept   = i_s_tvalid && o_s_tready;

    // Sequence commands and compute next state
    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_back      = r_back;
        n_count     = r_count;
        n_left      = r_left;
        n_key       = r_key;
        n_best      = r_best;
        n_found     = r_found;
        n_out_valid = r_out_valid && !i_m_tready;
        n_res_addr  = r_res_addr;
        n_res_err   = r_res_err;
        n_res_cnt   = r_res_cnt;
        w_ctl.push  = 1'b0;
        w_ctl.step  = 1'b0;
        w_ctl.keep  = 1'b0;
        w_ctl.cnt   = r_count;
        w_ctl.head  = w_val[0];
        w_ctl.wdata = w_new_back;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_out_valid = 1'b1;
                    n_res_addr  = '0;
                    n_res_err   = hac_pkg::ERR_OK;
                    n_res_cnt   = r_count;
                    unique case (w_op)
                        hac_pkg::OP_BUMP: begin
                            if (w_bump_sum >= HUNK_S) begin
                                n_res_err = hac_pkg::ERR_FRONT;
                            end else begin
                                n_res_addr = r_front;
                                n_front    = w_front_sum[hac_pkg::ADDR_W-1:0];
                            end
                        end
                        hac_pkg::OP_MARK: begin
                            n_res_addr = r_front;
                        end
                        hac_pkg::OP_RESET: begin
                            if (w_addr > r_front) begin
                                n_res_err = hac_pkg::ERR_BADRST;
                            end else begin
                                n_front    = w_addr;
                                n_res_addr = w_addr;
                            end
                        end
                        hac_pkg::OP_TALLOC: begin
                            if (w_temp_sum >= HUNK_S) begin
                                n_res_err = hac_pkg::ERR_BACK;
                            end else if (r_count >= SLOTS_C) begin
                                n_res_err = hac_pkg::ERR_SLOTS;
                            end else begin
                                w_ctl.push = 1'b1;
                                n_back     = w_new_back;
                                n_count    = r_count + hac_pkg::CNT_W'(1);
                                n_res_cnt  = r_count + hac_pkg::CNT_W'(1);
                                n_res_addr = w_talloc_addr[hac_pkg::ADDR_W-1:0];
                            end
                        end
                        hac_pkg::OP_TFREE: begin
                            if ((hac_pkg::SUM_W'(w_addr) > HUNK_S) || (r_count == '0)) begin
                                n_res_err = hac_pkg::ERR_NOTFOUND;
                            end else begin
                                n_out_valid = 1'b0;
                                n_key       = w_key_diff[hac_pkg::ADDR_W-1:0];
                                n_left      = r_count;
                                n_best      = '0;
                                n_found     = 1'b0;
                                n_state     = S_SCAN;
                            end
                        end
                        hac_pkg::OP_CHECK: begin
                            if (r_back != '0) begin
                                n_res_err = hac_pkg::ERR_HELD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // Rotate the chain; drop matches, keep the largest survivor
                w_ctl.step = 1'b1;
                w_ctl.keep = !w_match;
                if (w_match) begin
                    n_found = 1'b1;
                    n_count = r_count - hac_pkg::CNT_W'(1);
                end else if (w_val[0] > r_best) begin
                    n_best = w_val[0];
                end
                n_left = r_left - hac_pkg::CNT_W'(1);
                if (r_left == hac_pkg::CNT_W'(1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // Publish the free result once the output register is free
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_res_addr  = '0;
                    n_res_cnt   = r_count;
                    n_res_err   = r_found ? hac_pkg::ERR_OK : hac_pkg::ERR_NOTFOUND;
                    if (r_found) begin
                        n_back = r_best;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_back      <= '0;
            r_count     <= '0;
            r_left      <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_back      <= n_back;
            r_count     <= n_count;
            r_left      <= n_left;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
        r_key      <= n_key;
        r_best     <= n_best;
        r_res_addr <= n_res_addr;
        r_res_err  <= n_res_err;
        r_res_cnt  <= n_res_cnt;
    end

    // Slot chain: each cell hands its value to its left neighbor on a step
    for (genvar g = 0; g < hac_pkg::TEMP_SLOTS; g++) begin : g_cell
        logic [hac_pkg::ADDR_W-1:0] w_next;
        if (g == hac_pkg::TEMP_SLOTS - 1) begin : g_tail
            assign w_next = w_val[g];
        end else begin : g_body
            assign w_next = w_val[g+1];
        end
        hac_cell u_cell (
            .i_clk   (i_clk),
            .i_index (hac_pkg::IDX_W'(g)),
            .i_ctl   (w_ctl),
            .i_next  (w_next),
            .o_val   (w_val[g])
        );
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_res_cnt, r_res_err, r_res_addr};

    // Slot count never exceeds the table depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= SLOTS_C)
        else $error("slot count beyond table depth");

    // Front and back regions never meet
    a_levels_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_used < HUNK_S)
        else $error("front and back levels overlap");

    // Remaining scan steps never exceed the live slot count
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_left <= r_count))
        else $error("scan step count exceeds slot count");

    // A failed command reports address zero
    a_err_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_res_err != hac_pkg::ERR_OK)) |-> (r_res_addr == '0))
        else $error("error result carries an address");

endmodule

FILE: bench/hunk_alloc_checker.sv
// Checker of the hunk allocator: watches both streams, predicts each result, compares.
`timescale 1ns / 100ps
module hunk_alloc_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    input  logic                         i_s_tready,
    // [2:0] op, [25:3] req_size, [48:26] req_addr, [55:49] zero
    input  logic [hac_pkg::S_DATA_W-1:0] i_s_tdata,
    input  logic                         i_m_tvalid,
    input  logic                         i_m_tready,
    // [22:0] result_addr, [25:23] error_code, [30:26] temp_count, [31] zero
    input  logic [hac_pkg::M_DATA_W-1:0] i_m_tdata,
    output int                           o_fail_count,
    output int                           o_pending
);

    localparam int ADDR_W = hac_pkg::ADDR_W;
    localparam int SUM_W  = hac_pkg::SUM_W;
    localparam int CNT_W  = hac_pkg::CNT_W;
    localparam int OP_W   = hac_pkg::OP_W;
    localparam int ERR_W  = hac_pkg::ERR_W;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        hac_pkg::t_err     err;
        logic [CNT_W-1:0]  cnt;
    } t_alloc_result;

    // Shadow of the allocator state
    logic [ADDR_W-1:0] front_lvl;
    logic [ADDR_W-1:0] back_lvl;
    logic [ADDR_W-1:0] slot_tab [hac_pkg::TEMP_SLOTS];
    logic [CNT_W-1:0]  slot_cnt;

    t_alloc_result expected_q [$];
    t_alloc_result want_r;
    t_alloc_result got_r;
    int            fails = 0;

    // Apply one command to the shadow state and return the result it must produce
    function automatic t_alloc_result apply_hunk_cmd(input logic [OP_W-1:0]   op,
                                                     input logic [ADDR_W-1:0] size,
                                                     input logic [ADDR_W-1:0] addr);
        logic [SUM_W-1:0]  need;
        logic [SUM_W-1:0]  rsize;
        logic [ADDR_W-1:0] key;
        logic [ADDR_W-1:0] best;
        int                kept;
        bit                hit;
        t_alloc_result     r;

        r.addr = '0;
        r.err  = hac_pkg::ERR_OK;
        case (op)
            hac_pkg::OP_BUMP: begin
                need = SUM_W'(front_lvl) + SUM_W'(back_lvl) + SUM_W'(size);
                if (need >= hac_pkg::HUNK_BYTES) begin
                    r.err = hac_pkg::ERR_FRONT;
                end else begin
                    r.addr    = front_lvl;
                    front_lvl = front_lvl + size;
                end
            end
            hac_pkg::OP_MARK: begin
                r.addr = front_lvl;
            end
            hac_pkg::OP_RESET: begin
                if (addr > front_lvl) begin
                    r.err = hac_pkg::ERR_BADRST;
                end else begin
                    front_lvl = addr;
                    r.addr    = front_lvl;
                end
            end
            hac_pkg::OP_TALLOC: begin
                // round up to the 8-byte grain
                rsize = (SUM_W'(size) + SUM_W'(hac_pkg::ALIGN_MASK))
                      & ~SUM_W'(hac_pkg::ALIGN_MASK);
                need  = SUM_W'(front_lvl) + SUM_W'(back_lvl) + rsize;
                if (need >= hac_pkg::HUNK_BYTES) begin
                    r.err = hac_pkg::ERR_BACK;
                end else if (slot_cnt >= hac_pkg::TEMP_SLOTS) begin
                    r.err = hac_pkg::ERR_SLOTS;
                end else begin
                    back_lvl           = back_lvl + rsize[ADDR_W-1:0];
                    slot_tab[slot_cnt] = back_lvl;
                    slot_cnt           = slot_cnt + 1'b1;
                    r.addr             = ADDR_W'(hac_pkg::HUNK_BYTES - back_lvl);
                end
            end
            hac_pkg::OP_TFREE: begin
                hit = 1'b0;
                key = '0;
                if (addr <= hac_pkg::HUNK_BYTES) begin
                    key = ADDR_W'(hac_pkg::HUNK_BYTES - addr);
                    for (int i = 0; i < slot_cnt; i++)
                        if (slot_tab[i] == key)
                            hit = 1'b1;
                end
                if (!hit) begin
                    r.err = hac_pkg::ERR_NOTFOUND;
                end else begin
                    // drop every match, keep order, track the largest survivor
                    kept = 0;
                    best = '0;
                    for (int i = 0; i < slot_cnt; i++) begin
                        if (slot_tab[i] != key) begin
                            if (slot_tab[i] > best)
                                best = slot_tab[i];
                            slot_tab[kept] = slot_tab[i];
                            kept++;
                        end
                    end
                    slot_cnt = CNT_W'(kept);
                    back_lvl = best;
                end
            end
            hac_pkg::OP_CHECK: begin
                r.err = (back_lvl != '0) ? hac_pkg::ERR_HELD : hac_pkg::ERR_OK;
            end
            default: begin
            end
        endcase
        r.cnt = slot_cnt;
        return r;
    endfunction

    // Compare result transactions first, then record the prediction for a new command
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            front_lvl = '0;
            back_lvl  = '0;
            slot_cnt  = '0;
            expected_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got_r.addr = i_m_tdata[ADDR_W-1:0];
                got_r.err  = hac_pkg::t_err'(i_m_tdata[ADDR_W+ERR_W-1:ADDR_W]);
                got_r.cnt  = i_m_tdata[ADDR_W+ERR_W+CNT_W-1:ADDR_W+ERR_W];
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result transaction, expected none, got %h",
                             $time, i_m_tdata);
                    fails++;
                end else begin
                    want_r = expected_q.pop_front();
                    if (got_r.addr !== want_r.addr) begin
                        $display("%0t: result_addr expected %0h, got %0h",
                                 $time, want_r.addr, got_r.addr);
                        fails++;
                    end
                    if (got_r.err !== want_r.err) begin
                        $display("%0t: error_code expected %0d, got %0d",
                                 $time, want_r.err, got_r.err);
                        fails++;
                    end
                    if (got_r.cnt !== want_r.cnt) begin
                        $display("%0t: temp_count expected %0d, got %0d",
                                 $time, want_r.cnt, got_r.cnt);
                        fails++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                expected_q.push_back(apply_hunk_cmd(i_s_tdata[OP_W-1:0],
                                                    i_s_tdata[OP_W+ADDR_W-1:OP_W],
                                                    i_s_tdata[OP_W+2*ADDR_W-1:OP_W+ADDR_W]));
        end
        o_pending    <= expected_q.size();
        o_fail_count <= fails;
    end

endmodule

FILE: bench/double_ended_hunk_allocator_core_tb.sv
// Testbench top of the hunk allocator: clock, reset, command stimulus and verdict.
`timescale 1ns / 100ps
module double_ended_hunk_allocator_core_tb;

    localparam int RANDOM_CMDS  = 750;
    localparam int DRAIN_CYCLES = 40;
    localparam int POOL_DEPTH   = 48;

    localparam int ADDR_W     = hac_pkg::ADDR_W;
    localparam int OP_W       = hac_pkg::OP_W;
    localparam int ERR_W      = hac_pkg::ERR_W;
    localparam int S_DATA_W   = hac_pkg::S_DATA_W;
    localparam int M_DATA_W   = hac_pkg::M_DATA_W;
    localparam int HUNK_BYTES = hac_pkg::HUNK_BYTES;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    int                  fail_count;
    int                  pending;

    // Addresses handed out, reused to build frees and front rollbacks
    logic [OP_W-1:0]     inflight_ops [$];
    logic [ADDR_W-1:0]   temp_addrs [$];
    logic [ADDR_W-1:0]   front_marks [$];
    logic [OP_W-1:0]     done_op;

    int                  stall_left = 0;
    bit                  rx_idle_on = 1'b1;
    bit                  tx_idle_on = 1'b1;

    always #10 clk = ~clk;

    double_ended_hunk_allocator_core uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    hunk_alloc_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Randomly stall the result stream after each transaction while rx_idle_on is set
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready   <= 1'b0;
            stall_left = 0;
        end else if (m_tvalid && m_tready) begin
            if ($urandom_range(0, 49) == 0)
                rx_idle_on = !rx_idle_on;
            stall_left = rx_idle_on ? $urandom_range(0, 3) : 0;
            m_tready <= (stall_left == 0);
        end else if (!m_tready) begin
            if (stall_left > 0)
                stall_left--;
            if (stall_left == 0)
                m_tready <= 1'b1;
        end
    end

    // Harvest returned addresses; sampled mid-cycle, away from the driving edge
    always @(negedge clk) begin
        if (rst_n) begin
            if (m_tvalid && m_tready && inflight_ops.size() > 0) begin
                done_op = inflight_ops.pop_front();
                if (m_tdata[ADDR_W+ERR_W-1:ADDR_W] == hac_pkg::ERR_OK) begin
                    if (done_op == hac_pkg::OP_TALLOC)
                        temp_addrs.push_back(m_tdata[ADDR_W-1:0]);
                    else if (done_op == hac_pkg::OP_MARK || done_op == hac_pkg::OP_BUMP
                             || done_op == hac_pkg::OP_RESET)
                        front_marks.push_back(m_tdata[ADDR_W-1:0]);
                end
                if (temp_addrs.size() > POOL_DEPTH)
                    void'(temp_addrs.pop_front());
                if (front_marks.size() > POOL_DEPTH)
                    void'(front_marks.pop_front());
            end
            if (s_tvalid && s_tready)
                inflight_ops.push_back(s_tdata[OP_W-1:0]);
        end
    end

    // Send one command transaction after a random gap
    task automatic issue_cmd(input logic [OP_W-1:0]   op,
                             input logic [ADDR_W-1:0] size,
                             input logic [ADDR_W-1:0] addr);
        int gap;

        gap = tx_idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'({addr, size, op});
        do @(posedge clk); while (!s_tready);
    endtask

    // Hold off the command stream until every predicted result has arrived
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    initial begin
        int                sel;
        int                k;
        int                idx;
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] size;
        logic [ADDR_W-1:0] addr;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty state, front limits, rollback
        issue_cmd(hac_pkg::OP_CHECK, '0, '0);
        issue_cmd(hac_pkg::OP_MARK, '0, '0);
        issue_cmd(hac_pkg::OP_TFREE, '0, ADDR_W'(HUNK_BYTES));     // free with empty table
        issue_cmd(hac_pkg::OP_BUMP, '0, '0);
        issue_cmd(hac_pkg::OP_BUMP, '1, '0);                       // far too large
        issue_cmd(hac_pkg::OP_BUMP, ADDR_W'(HUNK_BYTES - 1), '0);  // fills to one below the top
        issue_cmd(hac_pkg::OP_BUMP, ADDR_W'(1), '0);               // would exactly reach the top, so refused
        issue_cmd(hac_pkg::OP_RESET, '0, '1);                      // rollback above the front
        issue_cmd(hac_pkg::OP_RESET, '0, '0);

        // Directed: rounding, zero-size temps, check with back level still zero
        issue_cmd(hac_pkg::OP_TALLOC, '0, '0);
        issue_cmd(hac_pkg::OP_CHECK, '0, '0);
        issue_cmd(hac_pkg::OP_TALLOC, ADDR_W'(1), '0);
        issue_cmd(hac_pkg::OP_TALLOC, ADDR_W'(9), '0);
        issue_cmd(hac_pkg::OP_TALLOC, '0, '0);                     // duplicate table entry
        issue_cmd(hac_pkg::OP_CHECK, '0, '0);
        issue_cmd(hac_pkg::OP_TFREE, '0, ADDR_W'(HUNK_BYTES - 24)); // removes both duplicates
        issue_cmd(hac_pkg::OP_TFREE, '0, ADDR_W'(HUNK_BYTES + 1));  // beyond the hunk
        issue_cmd(hac_pkg::OP_TFREE, '0, '1);
        issue_cmd(hac_pkg::OP_TFREE, '0, ADDR_W'(HUNK_BYTES - 12345)); // no such entry
        issue_cmd(hac_pkg::OP_TALLOC, '1, '0);                     // back side overflow
        issue_cmd(OP_W'(6), '1, '1);
        issue_cmd(OP_W'(7), '0, '0);

        // Directed: fill the slot table past its depth, then free the zero entry
        repeat (hac_pkg::TEMP_SLOTS - 1) issue_cmd(hac_pkg::OP_TALLOC, ADDR_W'(8), '0);
        issue_cmd(hac_pkg::OP_TFREE, '0, ADDR_W'(HUNK_BYTES));

        wait_results_drained();

        // Random: mix of all ops; frees mostly of live temps, rollbacks mostly to seen marks
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            if (n % 250 == 125)
                wait_results_drained();
            if ($urandom_range(0, 39) == 0)
                tx_idle_on = !tx_idle_on;
            sel  = $urandom_range(0, 99);
            k    = $urandom_range(0, 19);
            size = ADDR_W'($urandom_range(0, 4096));
            addr = ADDR_W'($urandom);
            if (sel < 18) begin
                op = hac_pkg::OP_BUMP;
                if (k == 0)
                    size = ADDR_W'($urandom);
                else if (k < 3)
                    size = ADDR_W'($urandom_range(HUNK_BYTES / 8, HUNK_BYTES));
            end else if (sel < 26) begin
                op = hac_pkg::OP_MARK;
            end else if (sel < 34) begin
                op = hac_pkg::OP_RESET;
                if (k < 4)
                    addr = '0;
                else if (k < 17 && front_marks.size() > 0)
                    addr = front_marks[$urandom_range(0, front_marks.size() - 1)];
            end else if (sel < 60) begin
                op   = hac_pkg::OP_TALLOC;
                size = ADDR_W'($urandom_range(0, 512));
                if (k == 0)
                    size = ADDR_W'($urandom);
                else if (k == 1)
                    size = ADDR_W'($urandom_range(HUNK_BYTES / 16, HUNK_BYTES / 2));
            end else if (sel < 88) begin
                op = hac_pkg::OP_TFREE;
                if (k < 16 && temp_addrs.size() > 0) begin
                    idx  = $urandom_range(0, temp_addrs.size() - 1);
                    addr = temp_addrs[idx];
                    if (k < 14)
                        temp_addrs.delete(idx);
                end else if (k < 18) begin
                    addr = ADDR_W'(HUNK_BYTES - 8 * $urandom_range(0, 64));
                end
            end else if (sel < 95) begin
                op = hac_pkg::OP_CHECK;
            end else begin
                op = OP_W'($urandom_range(6, 7));
            end
            issue_cmd(op, size, addr);
        end

        // Drain and give the verdict
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
